[design/ammo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ammo_pkg
// Shared types, the AES S-box and the AES round helpers for the MMO generator.
// ----------------------------------------------------------------------------
package ammo_pkg;

    localparam int unsigned KEY_SLOTS = 2;
    localparam int unsigned ROUNDS    = 10;

    // One block travelling down the round pipeline.
    typedef struct packed {
        logic         valid;
        logic         last;
        logic         idx;
        logic [127:0] seed;
        logic [127:0] state;
        logic [127:0] rkey;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 sits in the most significant bits of the 128-bit word.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3, all;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = t[127 - 32 * c -: 8];
            a1  = t[119 - 32 * c -: 8];
            a2  = t[111 - 32 * c -: 8];
            a3  = t[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            m[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            m[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return m;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] sw;
        for (int i = 0; i < 4; i++) begin
            w[i] = rk[127 - 32 * i -: 32];
        end
        sw = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ sw;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        return {w[0], w[1], w[2], w[3]};
    endfunction

endpackage
`default_nettype wire

[design/ammo_issue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ammo_issue
// Holds one request and feeds its blocks, one per cycle while en is high, into the pipeline.
// ----------------------------------------------------------------------------
module ammo_issue #(
    parameter int unsigned BLOCKS = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [127:0]      seed,
    input  wire logic [1:0]        block_count,
    input  wire logic [127:0]      key0,
    input  wire logic [127:0]      key1,
    output ammo_pkg::stage_t       st_out
);

    localparam int unsigned LIMIT = (BLOCKS < ammo_pkg::KEY_SLOTS) ? BLOCKS : ammo_pkg::KEY_SLOTS;
    localparam logic [1:0]  LIM   = 2'(LIMIT);

    logic         hold_valid_reg, hold_valid_next;
    logic [127:0] seed_reg;
    logic [1:0]   count_reg;
    logic         idx_reg, idx_next;
    logic [1:0]   count_sat;
    logic         is_last;
    logic         accept;
    ammo_pkg::stage_t st_reg;
    logic [127:0] key_sel;

    assign count_sat = (block_count > LIM) ? LIM : block_count;
    assign is_last   = ({1'b0, idx_reg} + 2'd1) == count_reg;
    assign in_ready  = !hold_valid_reg || (en && is_last);
    assign accept    = in_valid && in_ready;
    assign key_sel   = idx_reg ? key1 : key0;
    assign st_out    = st_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        if (accept) begin
            hold_valid_next = (count_sat != 2'd0);
            idx_next        = 1'b0;
        end else if (hold_valid_reg && en) begin
            if (is_last) begin
                hold_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 1'b0;
            st_reg.valid   <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
            if (en) begin
                st_reg.valid <= hold_valid_reg;
            end
        end
        if (accept) begin
            seed_reg  <= seed;
            count_reg <= count_sat;
        end
        if (en) begin
            st_reg.last  <= is_last;
            st_reg.idx   <= idx_reg;
            st_reg.seed  <= seed_reg;
            st_reg.state <= seed_reg ^ key_sel;
            st_reg.rkey  <= key_sel;
        end
    end

endmodule
`default_nettype wire

[design/ammo_round.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ammo_round
// One registered AES round with its own on-the-fly round key expansion.
// ----------------------------------------------------------------------------
module ammo_round #(
    parameter int unsigned ROUND = 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  ammo_pkg::stage_t  st_in,
    output ammo_pkg::stage_t  st_out
);

    localparam logic IS_FINAL = (ROUND == ammo_pkg::ROUNDS);

    ammo_pkg::stage_t st_reg;
    logic [127:0] sub_q, mixed, rk_next, state_next;

    assign sub_q      = ammo_pkg::sub_shift(st_in.state);
    assign mixed      = IS_FINAL ? sub_q : ammo_pkg::mix_columns(sub_q);
    assign rk_next    = ammo_pkg::key_step(st_in.rkey, ammo_pkg::RCON[ROUND - 1]);
    // The last round also folds in the feed-forward of the seed.
    assign state_next = IS_FINAL ? (mixed ^ rk_next ^ st_in.seed) : (mixed ^ rk_next);
    assign st_out     = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg.valid <= st_in.valid;
        end
        if (en) begin
            st_reg.last  <= st_in.last;
            st_reg.idx   <= st_in.idx;
            st_reg.seed  <= st_in.seed;
            st_reg.state <= state_next;
            st_reg.rkey  <= rk_next;
        end
    end

endmodule
`default_nettype wire

[design/aes128_mmo_prg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_mmo_prg
// AES-128 Matyas-Meyer-Oseas generator: one output beat per block per seed.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  s_axis    in   seed_hi, seed_lo, block_count
//  m_axis    out  block_index, out_hi, out_lo, last on tlast
//  cfg       in   key0_hi, key0_lo, key1_hi, key1_lo by index
//
// A request holds the input until its blocks are issued (a zero count is
// taken and issues no block); blocks enter the round pipeline one per cycle
// while the output beat is not held. Each block passes the eleven-register
// AES pipeline (key whitening plus ten rounds, with round keys expanded
// alongside the data) on its way to the output, the second block of a
// request right behind the first.
// Reset is synchronous and active low and clears only the valid bits, the
// block index and the key registers. When the output beat is held, the whole
// pipeline freezes, so no block is dropped or repeated.
module aes128_mmo_prg #(
    parameter int unsigned BLOCKS = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // seed_hi, seed_lo, block_count
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // block_index, out_hi, out_lo
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wdata
);

    localparam logic [1:0] REG_KEY0_HI = 2'd0;
    localparam logic [1:0] REG_KEY0_LO = 2'd1;
    localparam logic [1:0] REG_KEY1_HI = 2'd2;
    localparam logic [1:0] REG_KEY1_LO = 2'd3;

    logic [63:0] key0_hi_reg, key0_lo_reg, key1_hi_reg, key1_lo_reg;
    logic        en;

    ammo_pkg::stage_t stg [ammo_pkg::ROUNDS + 1];

    // Key registers: the user must write them only while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_hi_reg <= '0;
            key0_lo_reg <= '0;
            key1_hi_reg <= '0;
            key1_lo_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_KEY0_HI: key0_hi_reg <= cfg_wdata;
                REG_KEY0_LO: key0_lo_reg <= cfg_wdata;
                REG_KEY1_HI: key1_hi_reg <= cfg_wdata;
                REG_KEY1_LO: key1_lo_reg <= cfg_wdata;
                default:     key0_hi_reg <= key0_hi_reg;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a beat.
    assign en = !stg[ammo_pkg::ROUNDS].valid || m_tready;

    // The seed word carries byte 0 in its top bits, so seed_hi goes on top.
    ammo_issue #(
        .BLOCKS (BLOCKS)
    ) u_issue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .seed        ({s_tdata[63:0], s_tdata[127:64]}),
        .block_count (s_tdata[129:128]),
        .key0        ({key0_hi_reg, key0_lo_reg}),
        .key1        ({key1_hi_reg, key1_lo_reg}),
        .st_out      (stg[0])
    );

    for (genvar r = 1; r <= ammo_pkg::ROUNDS; r++) begin : g_round
        ammo_round #(
            .ROUND (r)
        ) u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .st_in   (stg[r - 1]),
            .st_out  (stg[r])
        );
    end

    assign m_tvalid = stg[ammo_pkg::ROUNDS].valid;
    assign m_tlast  = stg[ammo_pkg::ROUNDS].last;
    assign m_tdata  = {7'd0, stg[ammo_pkg::ROUNDS].state[63:0],
                       stg[ammo_pkg::ROUNDS].state[127:64], stg[ammo_pkg::ROUNDS].idx};

endmodule
`default_nettype wire

[design/ammo_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ammo_checker
// Port-level checks on the result stream of the MMO generator.
// ----------------------------------------------------------------------------
module ammo_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic         m_tlast
);

    // No result may be offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The second block is always the final one of its request.
    a_second_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tlast)
        else $error("second block not marked last");

    // A block that is not final must be the first of its request.
    a_first_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tdata[0])
        else $error("non-final block has nonzero index");

    // A non-final block is followed by the second block of the same request.
    a_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tdata[0])
        else $error("first block not followed by second");

endmodule

bind aes128_mmo_prg ammo_checker u_ammo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-128 Matyas-Meyer-Oseas generator. Seeds and
// block counts go in on the slave stream. An internal AES-128 predictor works
// out every output block, and each output beat is checked against the oldest
// pending block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes of the key bank.
    localparam logic [1:0] REG_KEY0_HI = 2'd0;
    localparam logic [1:0] REG_KEY0_LO = 2'd1;
    localparam logic [1:0] REG_KEY1_HI = 2'd2;
    localparam logic [1:0] REG_KEY1_LO = 2'd3;
    localparam int         MAX_BLOCKS  = 2;
    // Pipeline depth plus margin. A request that asks for zero blocks makes no
    // beat and puts no block into the pipeline.
    localparam int         SETTLE      = 20;

    typedef struct {
        logic        idx;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } prg_block_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;    // seed_hi, seed_lo, block_count (low to high)
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [135:0] m_tdata;         // block_index, out_hi, out_lo (low to high)
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [63:0]  cfg_wdata = '0;

    aes128_mmo_prg dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state: its own copy of the key bank and an S-box built from
    // the field inverse, so nothing is borrowed from the design package.
    logic [127:0] key_bank [MAX_BLOCKS];
    logic [7:0]   sub_lut [256];
    prg_block_t   pending_blocks [$];
    int           fail_count = 0;
    int           beats_checked = 0;
    int           requests_sent = 0;
    int           key_writes = 0;
    bit           send_gaps = 1'b0;
    bit           recv_stalls = 1'b0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return gf_mul(x, 8'h02);
    endfunction

    task automatic build_sub_lut();
        logic [7:0] inv;
        logic [7:0] v;
        for (int n = 0; n < 256; n++) begin
            inv = 8'h01;
            // x^254 is the multiplicative inverse, and 0 maps to 0.
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, n[7:0]);
            if (n == 0) inv = 8'h00;
            v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_lut[n] = v;
        end
    endtask

    // FIPS-197 AES-128 on a byte array; byte 0 is the top byte of the word.
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [7:0]   rk [16];
        logic [7:0]   rc;
        logic [7:0]   w0, w1, w2, w3, a0, a1, a2, a3, all;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int round = 1; round <= 10; round++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r + 4 * c] = sub_lut[st[r + 4 * ((c + r) % 4)]];
            if (round != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tmp[4 * c]; a1 = tmp[4 * c + 1];
                    a2 = tmp[4 * c + 2]; a3 = tmp[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    tmp[4 * c]     = a0 ^ all ^ dbl(a0 ^ a1);
                    tmp[4 * c + 1] = a1 ^ all ^ dbl(a1 ^ a2);
                    tmp[4 * c + 2] = a2 ^ all ^ dbl(a2 ^ a3);
                    tmp[4 * c + 3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            end
            w0 = sub_lut[rk[13]] ^ rc; w1 = sub_lut[rk[14]];
            w2 = sub_lut[rk[15]];      w3 = sub_lut[rk[12]];
            rk[0] ^= w0; rk[1] ^= w1; rk[2] ^= w2; rk[3] ^= w3;
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
            rc = dbl(rc);
            for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    // Queue the blocks that one accepted request must produce.
    task automatic predict_blocks(input logic [63:0] seed_hi, input logic [63:0] seed_lo,
                                  input logic [1:0] count);
        int           n;
        logic [127:0] seed;
        logic [127:0] mmo;
        prg_block_t   blk;
        n = (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
        seed = {seed_hi, seed_lo};
        for (int i = 0; i < n; i++) begin
            mmo = aes_encrypt(key_bank[i], seed) ^ seed;
            blk.idx  = i[0];
            blk.hi   = mmo[127:64];
            blk.lo   = mmo[63:0];
            blk.last = (i + 1 == n);
            pending_blocks.push_back(blk);
        end
    endtask

    // Output side: random back-pressure bursts while recv_stalls is set.
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        m_tready <= (stall_left == 0);
    end

    // Checker: every output beat against the oldest pending block.
    always @(posedge aclk) begin
        prg_block_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected output beat: data %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = pending_blocks.pop_front();
                beats_checked++;
                if (m_tdata[0] !== want.idx) begin
                    $error("block_index: expected %0d, got %0d", want.idx, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[64:1] !== want.hi) begin
                    $error("out_hi: expected %h, got %h", want.hi, m_tdata[64:1]);
                    fail_count++;
                end
                if (m_tdata[128:65] !== want.lo) begin
                    $error("out_lo: expected %h, got %h", want.lo, m_tdata[128:65]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Drive one request beat and hold it until the block takes it. Valid is
    // left high on return so back-to-back requests need no idle gap between them.
    task automatic send_seed(input logic [63:0] seed_hi, input logic [63:0] seed_lo,
                             input logic [1:0] count);
        int gap;
        @(negedge aclk);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, count, seed_lo, seed_hi};
        do @(posedge aclk); while (!s_tready);
        predict_blocks(seed_hi, seed_lo, count);
        requests_sent++;
    endtask

    // Drop valid and wait until every block is out and the pipeline is empty.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_key(input logic [1:0] index, input logic [63:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (index[0]) key_bank[index[1]][63:0] = value;
        else          key_bank[index[1]][127:64] = value;
        key_writes++;
    endtask

    task automatic load_keys(input logic [127:0] k0, input logic [127:0] k1);
        write_key(REG_KEY0_HI, k0[127:64]);
        write_key(REG_KEY0_LO, k0[63:0]);
        write_key(REG_KEY1_HI, k1[127:64]);
        write_key(REG_KEY1_LO, k1[63:0]);
    endtask

    // After reset both keys are zero; try extreme seeds and every count,
    // including a zero count (no blocks) and three (saturates to two).
    task automatic test_reset_keys();
        for (int c = 0; c < 4; c++) begin
            send_seed('0, '0, c[1:0]);
            send_seed('1, '1, c[1:0]);
        end
        send_seed(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 2'd2);
        drain();
    endtask

    // The FIPS-197 example key and plaintext in slot 0, all-ones in slot 1.
    task automatic test_known_keys();
        load_keys(128'h000102030405060708090a0b0c0d0e0f, '1);
        send_seed(64'h0011223344556677, 64'h8899aabbccddeeff, 2'd2);
        send_seed(64'h0011223344556677, 64'h8899aabbccddeeff, 2'd1);
        send_seed('1, '0, 2'd3);
        send_seed('0, '1, 2'd0);
        send_seed(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 2'd2);
        drain();
        load_keys('1, '0);
        send_seed('0, '0, 2'd2);
        send_seed('1, '1, 2'd3);
        drain();
    endtask

    // Random seeds and counts over several key settings, with idling on both
    // sides when enabled; halfway through each phase the sender waits for the output.
    task automatic test_random_seeds(input int phases, input int per_phase);
        logic [127:0] k0, k1;
        for (int p = 0; p < phases; p++) begin
            k0 = {$urandom, $urandom, $urandom, $urandom};
            k1 = {$urandom, $urandom, $urandom, $urandom};
            load_keys(k0, k1);
            for (int i = 0; i < per_phase; i++) begin
                send_seed({$urandom, $urandom}, {$urandom, $urandom},
                          $urandom_range(0, 9) == 0 ? 2'd0 : 2'($urandom_range(1, 3)));
                if (i == per_phase / 2) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (pending_blocks.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end
    endtask

    initial begin
        build_sub_lut();
        key_bank[0] = '0;
        key_bank[1] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_keys();
        test_known_keys();
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        test_random_seeds(4, 300);
        // Last stretch at full rate with no idling on either side.
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        test_random_seeds(1, 260);

        $display("tb: %0d requests sent, %0d key writes, %0d output blocks checked",
                 requests_sent, key_writes, beats_checked);
        $display("tb: covered zero, saturating and full counts under random idling");
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end
endmodule
